[rtl/psa_pkg.sv]
// Shared types, codes and default constants of the paged stack allocator.
package psa_pkg;

    // Fixed field widths.
    localparam int ADDR_W   = 38;
    localparam int LEN_W    = 12;
    localparam int PAGES_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Default geometry.
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int STACK_DEPTH_DEF  = 256;

    // Configuration reset values.
    localparam logic [LEN_W-1:0]   LEN_LIMIT_RST = LEN_W'(512);
    localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = '0;
    localparam logic [PAGES_W-1:0] MAX_PAGES_RST = PAGES_W'(64);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES = 2'd2;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_NO_PAGES  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PC_NONE     = 2'd0,
        PC_TAKEN    = 2'd1,
        PC_RELEASED = 2'd2
    } page_change_t;

    // Commands from the allocator datapath to the block stack.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

endpackage

[rtl/paged_stack_allocator_top.sv]
// Paged stack allocator: LIFO block allocator over a page-granular heap.
//
// Input channel (in_valid / in_stall) carries operation and length; an item
// is taken at a clock edge with in_valid high and in_stall low. Each item
// gives exactly one result on the output channel (out_valid / out_stall):
// status, payload address of a pushed block, freed length of a popped block
// and whether one page was taken or released.
// An item's result is registered once the result register is empty or taken.
// Throughput: one item per cycle when out_stall is low; the input register,
// one pass of allocation logic and the result register form the only path,
// and the block stack refills its register from a prefetched memory read.
// When the receiver stalls, the result is held and one more item can still be
// taken into the input register; after that in_stall rises until the result
// is taken.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no item is in flight.
// Reset: the stack is empty, no pages are held, and the registers return to
// length limit 512, heap_base 0 and max_pages 64.
module paged_stack_allocator_top
    import psa_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [LEN_W-1:0]     length,
    // Output channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [ADDR_W-1:0]    address,
    output logic [LEN_W-1:0]     freed_length,
    output logic [1:0]           page_change
);

    localparam int ROOM_W  = $clog2(PAGE_BYTES);
    localparam int SUM_W   = ((ROOM_W > LEN_W) ? ROOM_W : LEN_W) + 2;
    localparam int DEP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = ADDR_W + LEN_W + ROOM_W;

    // Configuration registers.
    logic [LEN_W-1:0]   len_limit_reg;
    logic [ADDR_W-1:0]  heap_base_reg;
    logic [PAGES_W-1:0] max_pages_reg;

    // Input register.
    logic               in_valid_reg;
    logic               op_reg;
    logic [LEN_W-1:0]   len_reg;

    // Top block and page count.
    logic               top_valid_reg;
    logic               top_valid_next;
    logic [ADDR_W-1:0]  top_addr_reg;
    logic [ADDR_W-1:0]  top_addr_next;
    logic [LEN_W-1:0]   top_len_reg;
    logic [LEN_W-1:0]   top_len_next;
    logic [ROOM_W-1:0]  top_room_reg;
    logic [ROOM_W-1:0]  top_room_next;
    logic [PAGES_W-1:0] pages_reg;
    logic [PAGES_W-1:0] pages_next;

    // Result register.
    logic               out_valid_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [LEN_W-1:0]   freed_reg;
    page_change_t       pc_reg;

    // Result of the current pass.
    status_t            res_status;
    logic [ADDR_W-1:0]  res_addr;
    logic [LEN_W-1:0]   res_freed;
    page_change_t       res_pc;

    logic               advance;
    stack_cmd_t         stack_cmd;
    logic [DEP_W-1:0]   depth;
    logic [ENTRY_W-1:0] under;
    logic [ADDR_W-1:0]  under_addr;
    logic [LEN_W-1:0]   under_len;
    logic [ROOM_W-1:0]  under_room;

    logic [SUM_W-1:0]   need;
    logic [SUM_W-1:0]   room_fit;
    logic [SUM_W-1:0]   room_grow;
    logic               too_large;
    logic               no_page;
    logic               fits;
    logic               full;
    logic               release_page;
    logic [ADDR_W-1:0]  first_hdr;
    logic [ADDR_W-1:0]  next_hdr;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit_reg <= LEN_LIMIT_RST;
            heap_base_reg <= HEAP_BASE_RST;
            max_pages_reg <= MAX_PAGES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEN_LIMIT: len_limit_reg <= cfg_data[LEN_W-1:0];
                CFG_HEAP_BASE: heap_base_reg <= cfg_data;
                CFG_MAX_PAGES: max_pages_reg <= cfg_data[PAGES_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            op_reg  <= operation;
            len_reg <= length;
        end
    end

    assign {under_addr, under_len, under_room} = under;

    assign need      = SUM_W'(len_reg) + SUM_W'(HEADER_BYTES);
    assign too_large = (len_reg > len_limit_reg) || (need > SUM_W'(PAGE_BYTES));
    assign no_page   = (pages_reg >= max_pages_reg);
    assign fits      = (need <= SUM_W'(top_room_reg));
    assign full      = (depth == DEP_W'(STACK_DEPTH));
    assign room_fit  = SUM_W'(top_room_reg) - need;
    assign room_grow = SUM_W'(PAGE_BYTES) + SUM_W'(top_room_reg) - need;
    assign first_hdr = heap_base_reg + ADDR_W'(pages_reg) * ADDR_W'(PAGE_BYTES);
    assign next_hdr  = top_addr_reg + ADDR_W'(top_len_reg) + ADDR_W'(HEADER_BYTES);

    // A pop gives back the last page when the top block began at or before its start.
    assign release_page = (depth == '0) ||
        ((SUM_W'(top_len_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(top_room_reg))
            >= SUM_W'(PAGE_BYTES));

    always_comb
    begin
        res_status     = ST_OK;
        res_addr       = '0;
        res_freed      = '0;
        res_pc         = PC_NONE;
        top_valid_next = top_valid_reg;
        top_addr_next  = top_addr_reg;
        top_len_next   = top_len_reg;
        top_room_next  = top_room_reg;
        pages_next     = pages_reg;
        stack_cmd      = '0;
        case (op_reg)
            OP_PUSH:
            begin
                if (too_large)
                begin
                    res_status = ST_TOO_LARGE;
                end
                else if (!top_valid_reg)
                begin
                    if (no_page)
                    begin
                        res_status = ST_NO_PAGES;
                    end
                    else
                    begin
                        res_addr       = first_hdr + ADDR_W'(HEADER_BYTES);
                        res_pc         = PC_TAKEN;
                        pages_next     = pages_reg + 1'b1;
                        top_valid_next = 1'b1;
                        top_addr_next  = first_hdr;
                        top_len_next   = len_reg;
                        top_room_next  = ROOM_W'(SUM_W'(PAGE_BYTES) - need);
                    end
                end
                else if (full)
                begin
                    res_status = ST_FULL;
                end
                else if (!fits && no_page)
                begin
                    res_status = ST_NO_PAGES;
                end
                else
                begin
                    res_addr        = next_hdr + ADDR_W'(HEADER_BYTES);
                    stack_cmd.push  = 1'b1;
                    top_addr_next   = next_hdr;
                    top_len_next    = len_reg;
                    if (fits)
                    begin
                        top_room_next = ROOM_W'(room_fit);
                    end
                    else
                    begin
                        top_room_next = ROOM_W'(room_grow);
                        pages_next    = pages_reg + 1'b1;
                        res_pc        = PC_TAKEN;
                    end
                end
            end
            OP_POP:
            begin
                if (!top_valid_reg)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_freed = top_len_reg;
                    if (release_page && (pages_reg != '0))
                    begin
                        pages_next = pages_reg - 1'b1;
                        res_pc     = PC_RELEASED;
                    end
                    if (depth == '0)
                    begin
                        top_valid_next = 1'b0;
                        top_addr_next  = '0;
                        top_len_next   = '0;
                        top_room_next  = '0;
                    end
                    else
                    begin
                        stack_cmd.pop = 1'b1;
                        top_addr_next = under_addr;
                        top_len_next  = under_len;
                        top_room_next = under_room;
                    end
                end
            end
            default: ;
        endcase
        if (!advance)
        begin
            stack_cmd      = '0;
            top_valid_next = top_valid_reg;
            top_addr_next  = top_addr_reg;
            top_len_next   = top_len_reg;
            top_room_next  = top_room_reg;
            pages_next     = pages_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_valid_reg <= 1'b0;
            top_addr_reg  <= '0;
            top_len_reg   <= '0;
            top_room_reg  <= '0;
            pages_reg     <= '0;
        end
        else
        begin
            top_valid_reg <= top_valid_next;
            top_addr_reg  <= top_addr_next;
            top_len_reg   <= top_len_next;
            top_room_reg  <= top_room_next;
            pages_reg     <= pages_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= res_status;
            addr_reg   <= res_addr;
            freed_reg  <= res_freed;
            pc_reg     <= res_pc;
        end
    end

    psa_stack #(
        .ENTRY_W     (ENTRY_W),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (stack_cmd),
        .wr_entry ({top_addr_reg, top_len_reg, top_room_reg}),
        .depth    (depth),
        .under    (under)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign address      = addr_reg;
    assign freed_length = freed_reg;
    assign page_change  = pc_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while the result register can move");

    a_empty_no_saved: assert property (@(posedge clk) disable iff (!rst_n)
        !top_valid_reg |-> (depth == '0))
        else $error("saved blocks present under an empty top");

    a_page_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_pc == PC_TAKEN)) |=> (pages_reg == $past(pages_reg) + 1'b1))
        else $error("page taken without a page count step");

    a_refusal_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_status != ST_OK)) |=>
            ($stable(pages_reg) && $stable(top_valid_reg) && $stable(top_addr_reg)))
        else $error("refused item changed the allocator state");

endmodule

[rtl/psa_stack.sv]
// Block stack: the entry just below the top in a register, the rest in a memory.
module psa_stack
    import psa_pkg::*;
#(
    parameter int ENTRY_W     = 62,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  stack_cmd_t                          cmd,
    input  logic [ENTRY_W-1:0]                  wr_entry,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    depth,
    output logic [ENTRY_W-1:0]                  under
);

    localparam int DEP_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [DEP_W-1:0]   depth_reg;
    logic [DEP_W-1:0]   depth_next;
    logic [ENTRY_W-1:0] under_reg;
    logic [ENTRY_W-1:0] under_next;
    logic [ENTRY_W-1:0] prefetch_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;

    // The memory holds every saved entry except the newest one, which lives in under_reg.
    // prefetch_reg holds the entry two below the top, when there is one, so a pop can refill under_reg.
    always_comb
    begin
        depth_next = depth_reg;
        under_next = under_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + 1'b1;
            under_next = wr_entry;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - 1'b1;
            under_next = prefetch_reg;
        end
    end

    assign mem_we    = cmd.push && (depth_reg != '0);
    assign mem_waddr = IDX_W'(depth_reg - 1'b1);
    assign mem_raddr = IDX_W'(depth_next - DEP_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        under_reg <= under_next;
        if (mem_we)
        begin
            mem[mem_waddr] <= under_reg;
        end
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            prefetch_reg <= under_reg;
        end
        else
        begin
            prefetch_reg <= mem[mem_raddr];
        end
    end

    assign depth = depth_reg;
    assign under = under_reg;

    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("stack push and pop in the same cycle");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (depth_reg != '0))
        else $error("stack pop with no saved entry");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (depth_reg != DEP_W'(STACK_DEPTH)))
        else $error("stack push beyond its depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> (under_reg == $past(wr_entry)))
        else $error("pushed entry not in the register below the top");

endmodule
